// ===== rtl/core/pfw_pkg.sv =====
package pfw_pkg;

   // Field and register widths
   localparam int CFG_DIM_W    = 13;  // width_pixels / height_pixels
   localparam int CFG_BPR_W    = 12;  // bytes_per_row
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 13;
   localparam int COLOUR_W     = 4;
   localparam int ADDR_FIELD_W = 17;  // byte_address / read_address
   localparam int BYTE_W       = 8;
   localparam int RSP_DATA_W   = 32;  // byte_address + byte_data, padded to bytes
   localparam int PROD_W       = CFG_DIM_W + CFG_BPR_W;
   localparam int ADDR_SUM_W   = PROD_W + 1;
   localparam int MEM_ADDR_W   = 20;  // enough for the largest store

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ROTATION = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIRROR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BPR      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF     = 3'd6;

   // Request kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Depth modes
   localparam logic [1:0] DEPTH_1BPP = 2'd0;
   localparam logic [1:0] DEPTH_2BPP = 2'd1;
   localparam logic [1:0] DEPTH_4BPP = 2'd2;
   localparam logic [1:0] DEPTH_NONE = 2'd3;

   // Pixel masks, most significant pixel first
   localparam logic [BYTE_W-1:0] MASK_1BPP = 8'h80;
   localparam logic [BYTE_W-1:0] MASK_2BPP = 8'hC0;
   localparam logic [BYTE_W-1:0] MASK_4BPP = 8'hF0;

   typedef struct packed {
      logic [1:0]           rotation;
      logic [1:0]           mirror_mode;
      logic [CFG_DIM_W-1:0] width_pixels;
      logic [CFG_DIM_W-1:0] height_pixels;
      logic [CFG_BPR_W-1:0] bytes_per_row;
      logic [1:0]           depth_mode;
      logic                 half_select;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rotation:      2'd0,
      mirror_mode:   2'd0,
      width_pixels:  13'd1360,
      height_pixels: 13'd480,
      bytes_per_row: 12'd170,
      depth_mode:    DEPTH_1BPP,
      half_select:   1'b0
   };

   // One classified request, ready for the store
   typedef struct packed {
      logic                    ok;         // accepted flag of the response
      logic                    wr;         // read-modify-write the store
      logic [MEM_ADDR_W-1:0]   mem_addr;
      logic [ADDR_FIELD_W-1:0] byte_addr;
      logic [BYTE_W-1:0]       clr_mask;
      logic [BYTE_W-1:0]       set_bits;
   } item_type;

endpackage

// ===== rtl/core/pfw_ram.sv =====
module pfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pfw_front.sv =====
module pfw_front #(
   parameter int COORD_BITS  = 13,
   parameter int STORE_BYTES = 131072
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pfw_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic                                in_kind,
   input  logic [COORD_BITS-1:0]               in_x,
   input  logic [COORD_BITS-1:0]               in_y,
   input  logic [pfw_pkg::COLOUR_W-1:0]        in_colour,
   input  logic [pfw_pkg::ADDR_FIELD_W-1:0]    in_raddr,
   input  logic                                q_full,
   output logic                                push,
   output pfw_pkg::item_type                   push_item
);

   localparam int CW = (COORD_BITS > pfw_pkg::CFG_DIM_W) ? COORD_BITS : pfw_pkg::CFG_DIM_W;
   localparam int SW = CW + 3;
   localparam logic [pfw_pkg::ADDR_SUM_W-1:0] STORE_LIM = pfw_pkg::ADDR_SUM_W'(STORE_BYTES);

   logic advance;

   // Stage 1: rotate and mirror
   logic                                f1_vld_ff, f1_vld_in;
   logic                                f1_kind_ff;
   logic signed [SW-1:0]                f1_x_ff, f1_x_in;
   logic signed [SW-1:0]                f1_y_ff, f1_y_in;
   logic [pfw_pkg::COLOUR_W-1:0]        f1_colour_ff;
   logic [pfw_pkg::ADDR_FIELD_W-1:0]    f1_raddr_ff;

   // Stage 2: half select, bounds, packing, row multiply
   logic                                f2_vld_ff;
   logic                                f2_kind_ff;
   logic                                f2_ok_ff, f2_ok_in;
   logic [pfw_pkg::PROD_W-1:0]          f2_prod_ff, f2_prod_in;
   logic [pfw_pkg::CFG_DIM_W-1:0]       f2_xbyte_ff, f2_xbyte_in;
   logic [pfw_pkg::BYTE_W-1:0]          f2_clr_ff, f2_clr_in;
   logic [pfw_pkg::BYTE_W-1:0]          f2_set_ff, f2_set_in;
   logic [pfw_pkg::ADDR_FIELD_W-1:0]    f2_raddr_ff;

   logic signed [SW-1:0] px_s, py_s, w_s, h_s, x_src, y_src, xh;
   logic                 x_flip, y_flip, in_half;
   logic [pfw_pkg::CFG_DIM_W-1:0] ux, uy;
   logic [2:0]                    shift;
   logic [pfw_pkg::BYTE_W-1:0]    bits;
   logic [pfw_pkg::ADDR_SUM_W-1:0] addr_sum;

   assign advance  = !q_full;
   assign in_ready = advance;
   assign push     = advance && f2_vld_ff;

   assign w_s = SW'(cfg.width_pixels);
   assign h_s = SW'(cfg.height_pixels);

   // Rotation then mirror collapses to a swap plus one flip per axis
   always_comb begin
      px_s   = SW'(in_x);
      py_s   = SW'(in_y);
      x_src  = cfg.rotation[0] ? py_s : px_s;
      y_src  = cfg.rotation[0] ? px_s : py_s;
      x_flip = cfg.rotation[0] ^ cfg.rotation[1] ^ cfg.mirror_mode[0];
      y_flip = cfg.rotation[1] ^ cfg.mirror_mode[1];
      f1_x_in = x_flip ? (w_s - SW'(1) - x_src) : x_src;
      f1_y_in = y_flip ? (h_s - SW'(1) - y_src) : y_src;
      f1_vld_in = in_valid;
   end

   always_comb begin
      in_half = !cfg.half_select || !(f1_x_ff < w_s);
      xh      = cfg.half_select ? (f1_x_ff - w_s) : f1_x_ff;
      f2_ok_in = in_half && !xh[SW-1] && (xh < w_s) && !f1_y_ff[SW-1] && (f1_y_ff < h_s)
                 && (cfg.depth_mode != pfw_pkg::DEPTH_NONE);
      ux = xh[pfw_pkg::CFG_DIM_W-1:0];
      uy = f1_y_ff[pfw_pkg::CFG_DIM_W-1:0];
      f2_prod_in = pfw_pkg::PROD_W'(uy) * pfw_pkg::PROD_W'(cfg.bytes_per_row);
      unique case (cfg.depth_mode)
         pfw_pkg::DEPTH_1BPP: begin
            f2_xbyte_in = ux >> 3;
            shift       = ~ux[2:0];
            bits        = pfw_pkg::BYTE_W'(f1_colour_ff != '0) << 7;
            f2_clr_in   = pfw_pkg::MASK_1BPP;
         end
         pfw_pkg::DEPTH_2BPP: begin
            f2_xbyte_in = ux >> 2;
            shift       = {~ux[1:0], 1'b0};
            bits        = pfw_pkg::BYTE_W'(f1_colour_ff[1:0]) << 6;
            f2_clr_in   = pfw_pkg::MASK_2BPP;
         end
         default: begin
            f2_xbyte_in = ux >> 1;
            shift       = {~ux[0], 2'b00};
            bits        = pfw_pkg::BYTE_W'(f1_colour_ff) << 4;
            f2_clr_in   = pfw_pkg::MASK_4BPP;
         end
      endcase
      // Masks were built at the top pixel; slide them down to the target
      f2_clr_in = f2_clr_in >> (3'd7 - shift - ((cfg.depth_mode == pfw_pkg::DEPTH_1BPP) ? 3'd0 :
                  (cfg.depth_mode == pfw_pkg::DEPTH_2BPP) ? 3'd1 : 3'd3));
      f2_set_in = bits >> (3'd7 - shift - ((cfg.depth_mode == pfw_pkg::DEPTH_1BPP) ? 3'd0 :
                  (cfg.depth_mode == pfw_pkg::DEPTH_2BPP) ? 3'd1 : 3'd3));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (advance) begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_kind_ff   <= in_kind;
         f1_x_ff      <= f1_x_in;
         f1_y_ff      <= f1_y_in;
         f1_colour_ff <= in_colour;
         f1_raddr_ff  <= in_raddr;
         f2_kind_ff   <= f1_kind_ff;
         f2_ok_ff     <= f2_ok_in;
         f2_prod_ff   <= f2_prod_in;
         f2_xbyte_ff  <= f2_xbyte_in;
         f2_clr_ff    <= f2_clr_in;
         f2_set_ff    <= f2_set_in;
         f2_raddr_ff  <= f1_raddr_ff;
      end
   end

   // Final address and store range check, then classify
   always_comb begin
      addr_sum = pfw_pkg::ADDR_SUM_W'(f2_prod_ff) + pfw_pkg::ADDR_SUM_W'(f2_xbyte_ff);
      push_item = '0;
      if (f2_kind_ff == pfw_pkg::KIND_READ) begin
         push_item.ok        = pfw_pkg::ADDR_SUM_W'(f2_raddr_ff) < STORE_LIM;
         push_item.wr        = 1'b0;
         push_item.mem_addr  = pfw_pkg::MEM_ADDR_W'(f2_raddr_ff);
         push_item.byte_addr = f2_raddr_ff;
      end else if (f2_ok_ff && (addr_sum < STORE_LIM)) begin
         push_item.ok        = 1'b1;
         push_item.wr        = 1'b1;
         push_item.mem_addr  = addr_sum[pfw_pkg::MEM_ADDR_W-1:0];
         push_item.byte_addr = addr_sum[pfw_pkg::ADDR_FIELD_W-1:0];
         push_item.clr_mask  = f2_clr_ff;
         push_item.set_bits  = f2_set_ff;
      end
   end

endmodule

// ===== rtl/core/pfw_fifo.sv =====
module pfw_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfw_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_vld,
   output pfw_pkg::item_type head
);

   pfw_pkg::item_type               slot_ff [pfw_pkg::QUEUE_DEPTH];
   logic [pfw_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pfw_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pfw_pkg::QPTR_W:0]        count_ff, count_in;

   assign full     = count_ff == (pfw_pkg::QPTR_W + 1)'(pfw_pkg::QUEUE_DEPTH);
   assign head_vld = count_ff != '0;
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (pfw_pkg::QPTR_W + 1)'(push) - (pfw_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/pfw_back.sv =====
module pfw_back #(
   parameter int STORE_BYTES = 131072
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_vld,
   input  pfw_pkg::item_type                 q_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic [pfw_pkg::ADDR_FIELD_W-1:0]  rsp_addr,
   output logic [pfw_pkg::BYTE_W-1:0]        rsp_data
);

   localparam int MAW = $clog2(STORE_BYTES);

   logic                           b_vld_ff, b_vld_in;
   pfw_pkg::item_type              b_item_ff;
   logic                           fwd_ff, fwd_in;
   logic [pfw_pkg::BYTE_W-1:0]     fwd_data_ff;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic                           rsp_ok_ff;
   logic [pfw_pkg::ADDR_FIELD_W-1:0] rsp_addr_ff;
   logic [pfw_pkg::BYTE_W-1:0]     rsp_data_ff;

   logic                           out_free, b_adv, ram_we;
   logic [pfw_pkg::BYTE_W-1:0]     rd_data, cur, nv;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign b_adv    = b_vld_ff && out_free;
   assign pop      = q_vld && (!b_vld_ff || b_adv);
   assign ram_we   = b_adv && b_item_ff.wr;

   // Old byte comes from the store, or from the write that raced its read
   assign cur = fwd_ff ? fwd_data_ff : rd_data;
   assign nv  = b_item_ff.ok ? ((cur & ~b_item_ff.clr_mask) | b_item_ff.set_bits) : '0;

   assign fwd_in     = ram_we && (b_item_ff.mem_addr == q_item.mem_addr);
   assign b_vld_in   = pop || (b_vld_ff && !b_adv);
   assign rsp_vld_in = b_adv || (rsp_vld_ff && !rsp_ready);

   pfw_ram #(
      .WIDTH (pfw_pkg::BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (b_item_ff.mem_addr[MAW-1:0]),
      .wr_data (nv),
      .rd_en   (pop),
      .rd_addr (q_item.mem_addr[MAW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff   <= q_item;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= nv;
      end
      if (b_adv) begin
         rsp_ok_ff   <= b_item_ff.ok;
         rsp_addr_ff <= b_item_ff.byte_addr;
         rsp_data_ff <= nv;
      end
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_accepted = rsp_ok_ff;
   assign rsp_addr     = rsp_addr_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

// ===== rtl/core/packed_framebuffer_pixel_writer.sv =====
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | tuser: kind; tdata: pixel_x, pixel_y,
//         |           |                       |   colour, read_address
// rsp     | out       | rsp_tvalid/rsp_tready | tuser: accepted; tdata: byte_address,
//         |           |                       |   byte_data
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// Sustained rate is one request per cycle while responses are taken; the store's
// read-modify-write sets it, with a one-deep forward covering a write that races
// the next read. A response passes two front stages, the queue, the store read and
// the response register after its request is taken.
// Reset is synchronous; it clears control state and loads register defaults, never the store.
// A stalled response backs up the queue and then the front, which drops req_tready.
module packed_framebuffer_pixel_writer #(
   parameter int STORE_BYTES = 131072,
   parameter int COORD_BITS  = 13
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [COORD_BITS-1:0] pixel_x, then pixel_y, colour (4), read_address (17), zero pad
   input  logic [((2*COORD_BITS+pfw_pkg::COLOUR_W+pfw_pkg::ADDR_FIELD_W+7)/8)*8-1:0]
                                               req_tdata,
   // [0] kind
   input  logic                                req_tuser,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [16:0] byte_address, [24:17] byte_data, zero pad
   output logic [pfw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] accepted
   output logic                                rsp_tuser,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pfw_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int Y_LO = COORD_BITS;
   localparam int C_LO = 2 * COORD_BITS;
   localparam int A_LO = C_LO + pfw_pkg::COLOUR_W;

   pfw_pkg::cfg_type cfg_ff;

   logic              q_full, push, pop, q_vld;
   pfw_pkg::item_type push_item, q_item;
   logic              rsp_ok;
   logic [pfw_pkg::ADDR_FIELD_W-1:0] rsp_addr;
   logic [pfw_pkg::BYTE_W-1:0]       rsp_byte;

   // Register writes are always taken; software writes only while idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pfw_pkg::CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pfw_pkg::REG_ROTATION: cfg_ff.rotation      <= csr_data[1:0];
            pfw_pkg::REG_MIRROR:   cfg_ff.mirror_mode   <= csr_data[1:0];
            pfw_pkg::REG_WIDTH:    cfg_ff.width_pixels  <= csr_data;
            pfw_pkg::REG_HEIGHT:   cfg_ff.height_pixels <= csr_data;
            pfw_pkg::REG_BPR:      cfg_ff.bytes_per_row <= csr_data[pfw_pkg::CFG_BPR_W-1:0];
            pfw_pkg::REG_DEPTH:    cfg_ff.depth_mode    <= csr_data[1:0];
            pfw_pkg::REG_HALF:     cfg_ff.half_select   <= csr_data[0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Front: transform, bound, pack and compute the byte address
   pfw_front #(
      .COORD_BITS  (COORD_BITS),
      .STORE_BYTES (STORE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_x      (req_tdata[COORD_BITS-1:0]),
      .in_y      (req_tdata[Y_LO+COORD_BITS-1:Y_LO]),
      .in_colour (req_tdata[C_LO+pfw_pkg::COLOUR_W-1:C_LO]),
      .in_raddr  (req_tdata[A_LO+pfw_pkg::ADDR_FIELD_W-1:A_LO]),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   // Queue decouples the front from store stalls
   pfw_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .head_vld  (q_vld),
      .head      (q_item)
   );

   // Back: read-modify-write the store and hold the response
   pfw_back #(
      .STORE_BYTES (STORE_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_vld        (q_vld),
      .q_item       (q_item),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_accepted (rsp_ok),
      .rsp_addr     (rsp_addr),
      .rsp_data     (rsp_byte)
   );

   assign rsp_tuser = rsp_ok;
   assign rsp_tdata = pfw_pkg::RSP_DATA_W'({rsp_byte, rsp_addr});

endmodule
